### rtl/face_pose_from_five_landmarks_macros.svh
// Assertion helpers shared by the pose pipeline.
`ifndef FACE_POSE_FROM_FIVE_LANDMARKS_MACROS_SVH
`define FACE_POSE_FROM_FIVE_LANDMARKS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FPFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fpfl_pkg.sv
`timescale 1ns / 1ps

package fpfl_pkg;

    // Field and datapath widths
    localparam int COORD_W         = 16;
    localparam int OUT_W           = 16;
    localparam int DIFF_W          = 17;
    localparam int VEC_W           = 18;
    localparam int PROD_W          = 36;
    localparam int NN_W            = 35;
    localparam int DD_W            = 33;
    localparam int CR_W            = 36;
    localparam int NUM_W           = 39;
    localparam int PNUM_W          = 38;
    localparam int RATIO_FRAC_BITS = 12;

    // CORDIC
    localparam int CORDIC_STAGES = 16;
    localparam int CSH_W         = 4;
    localparam int CX_W          = 44;
    localparam int CZ_W          = 34;
    localparam int CPRE_SH       = 24;
    localparam int ATAN_W        = 30;
    localparam logic signed [CZ_W-1:0] ANGLE_PI = {{(CZ_W-32){1'b0}}, 32'h8000_0000};
    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STAGES] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861
    };

    // Square root and divider
    localparam int SQ_SH  = 16;
    localparam int ROOT_W = 26;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int SREM_W = ROOT_W + 2;
    localparam int DEN_W  = 2 * ROOT_W;
    localparam int QUO_W  = 17;
    localparam int YAW_SH = RATIO_FRAC_BITS + 15 - QUO_W;
    localparam int PSH    = QUO_W - RATIO_FRAC_BITS;

    // Register stages from input beat to output register
    localparam int PIPE_LAT = 50;

    typedef struct packed {
        logic [COORD_W-1:0] left_eye_x;
        logic [COORD_W-1:0] left_eye_y;
        logic [COORD_W-1:0] right_eye_x;
        logic [COORD_W-1:0] right_eye_y;
        logic [COORD_W-1:0] nose_x;
        logic [COORD_W-1:0] nose_y;
        logic [COORD_W-1:0] mouth_left_x;
        logic [COORD_W-1:0] mouth_left_y;
        logic [COORD_W-1:0] mouth_right_x;
        logic [COORD_W-1:0] mouth_right_y;
    } t_in_beat;

    typedef struct packed {
        logic signed [OUT_W-1:0] roll;
        logic signed [OUT_W-1:0] yaw;
        logic [OUT_W-1:0]        pitch;
        logic                    status;
    } t_out_beat;

endpackage

### rtl/fpfl_if.sv
`timescale 1ns / 1ps

// Landmark input channel
interface fpfl_in_if import fpfl_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Pose result channel
interface fpfl_out_if import fpfl_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/face_pose_from_five_landmarks.sv
`timescale 1ns / 1ps
// Channel  Dir  Beat                              Handshake
// i_in     in   ten landmark coordinates, Q12.4   valid/ready
// o_out    out  roll, yaw, pitch, status          valid/ready
//
// One beat per cycle while the output is not stalled.
// Depth is set by the 26-cell square-root row feeding the multiplier and
// the 17-cell yaw divider row behind it; CORDIC and pitch rows run alongside.
// Reset (synchronous, active low) empties the pipeline valid bits.
// A stalled output beat freezes the whole pipeline; i_in.ready drops with it.
`include "face_pose_from_five_landmarks_macros.svh"

module face_pose_from_five_landmarks import fpfl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpfl_in_if.sink     i_in,
    fpfl_out_if.source  o_out
);

    localparam int F_DLY = PIPE_LAT - 2;   // flags k2..k49
    localparam int N_DLY = PIPE_LAT - 5;   // cross sign k5..k49
    localparam int C_DLY = 27;             // cross magnitude k5..k31
    localparam int R_DLY = PIPE_LAT - 20;  // roll k20..k49
    localparam int P_DLY = PIPE_LAT - 24;  // pitch k24..k49

    localparam logic signed [CZ_W:0] ROUND_HALF = (CZ_W+1)'(32768);
    localparam logic signed [CZ_W:0] S16_MAX    = (CZ_W+1)'(32767);
    localparam logic signed [CZ_W:0] S16_MIN    = -(CZ_W+1)'(32768);

    logic            w_en, w_acc;
    logic [PIPE_LAT:1] r_vld;
    t_in_beat        w_b;

    // Stage 1: differences
    logic signed [DIFF_W-1:0] w_dx, w_dy, r1_dx, r1_dy;
    logic signed [VEC_W-1:0]  w_ex2, w_ey2, w_ux, w_uy, w_wx, w_wy;
    logic signed [VEC_W-1:0]  r1_ux, r1_uy, r1_wx, r1_wy;
    logic                     r1_eyes0, r1_cent0;

    // Stage 2: products and CORDIC prerotation
    logic signed [PROD_W-1:0] r2_uxx, r2_uyy, r2_dxx, r2_dyy;
    logic signed [PROD_W-1:0] r2_uywx, r2_uxwy, r2_uxwx, r2_uywy;
    logic signed [CX_W-1:0]   w_px, w_py, r2_cx, r2_cy;
    logic signed [CZ_W-1:0]   r2_cz;

    // Stage 3: sums
    logic [NN_W-1:0]          w_nn, r3_nn;
    logic signed [NUM_W-1:0]  w_dot;
    logic [DD_W-1:0]          r3_dd;
    logic signed [CR_W-1:0]   r3_cr;
    logic signed [NUM_W-1:0]  r3_num;

    // Stage 4: magnitudes
    logic signed [CR_W-1:0]   w_crn;
    logic signed [NUM_W-1:0]  w_numn;
    logic [CR_W-2:0]          r4_cr_abs;
    logic                     r4_cr_neg;
    logic [PNUM_W-1:0]        r4_pnum;
    logic [NN_W-1:0]          r4_nn;
    logic [DD_W-1:0]          r4_dd;

    // Stage 5: pitch divider setup
    logic [DEN_W-1:0] w_pr0, w_pd;
    logic [DEN_W-1:0] r5_prem, r5_pden;
    logic [QUO_W-1:0] r5_pfeed;
    logic             r5_povf;

    // Cell rows
    logic signed [CX_W-1:0] w_cx [CORDIC_STAGES+1];
    logic signed [CX_W-1:0] w_cy [CORDIC_STAGES+1];
    logic signed [CZ_W-1:0] w_cz [CORDIC_STAGES+1];
    logic [RAD_W-1:0]  w_nrad [ROOT_W+1];
    logic [SREM_W-1:0] w_nrem [ROOT_W+1];
    logic [ROOT_W-1:0] w_nrt  [ROOT_W+1];
    logic [RAD_W-1:0]  w_drad [ROOT_W+1];
    logic [SREM_W-1:0] w_drem [ROOT_W+1];
    logic [ROOT_W-1:0] w_drt  [ROOT_W+1];
    logic [DEN_W-1:0]  w_prem [QUO_W+1];
    logic [DEN_W-1:0]  w_pden [QUO_W+1];
    logic [QUO_W-1:0]  w_pfd  [QUO_W+1];
    logic [QUO_W-1:0]  w_pq   [QUO_W+1];
    logic              w_pov  [QUO_W+1];
    logic [DEN_W-1:0]  w_yrem [QUO_W+1];
    logic [DEN_W-1:0]  w_yden [QUO_W+1];
    logic [QUO_W-1:0]  w_yfd  [QUO_W+1];
    logic [QUO_W-1:0]  w_yq   [QUO_W+1];
    logic              w_yov  [QUO_W+1];

    // Roll rounding, pitch capping, den, yaw setup
    logic signed [CZ_W:0]   w_zt, w_zs;
    logic signed [OUT_W-1:0] r19_roll;
    logic [OUT_W-1:0]       r23_pitch;
    logic [DEN_W-1:0]       r31_den;
    logic [DEN_W-1:0]       w_yr0;
    logic [DEN_W-1:0]       r32_yrem, r32_yden;
    logic                   r32_yovf;

    // Delay lines
    logic [1:0]             r_fdly [F_DLY];
    logic                   r_ndly [N_DLY];
    logic [CR_W-2:0]        r_cdly [C_DLY];
    logic signed [OUT_W-1:0] r_rdly [R_DLY];
    logic [OUT_W-1:0]       r_pdly [P_DLY];

    // Output
    logic [QUO_W-1:0] w_ycap, w_ymag;
    logic             w_eyes0, w_cent0, w_yneg;
    t_out_beat        n_out, r_out;

    assign w_b   = i_in.data;
    assign w_en  = !r_vld[PIPE_LAT] || o_out.ready;
    assign w_acc = i_in.valid && w_en;
    assign i_in.ready = w_en;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-1:1], w_acc};
        end
    end

    // Stage 1: eye vector, mouth-minus-eye vector, nose-minus-eye vector
    always_comb begin
        w_dx  = $signed(DIFF_W'(w_b.right_eye_x) - DIFF_W'(w_b.left_eye_x));
        w_dy  = $signed(DIFF_W'(w_b.right_eye_y) - DIFF_W'(w_b.left_eye_y));
        w_ex2 = $signed(VEC_W'(w_b.left_eye_x) + VEC_W'(w_b.right_eye_x));
        w_ey2 = $signed(VEC_W'(w_b.left_eye_y) + VEC_W'(w_b.right_eye_y));
        w_ux  = $signed(VEC_W'(w_b.mouth_left_x) + VEC_W'(w_b.mouth_right_x)) - w_ex2;
        w_uy  = $signed(VEC_W'(w_b.mouth_left_y) + VEC_W'(w_b.mouth_right_y)) - w_ey2;
        w_wx  = $signed({1'b0, w_b.nose_x, 1'b0}) - w_ex2;
        w_wy  = $signed({1'b0, w_b.nose_y, 1'b0}) - w_ey2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx    <= w_dx;
            r1_dy    <= w_dy;
            r1_ux    <= w_ux;
            r1_uy    <= w_uy;
            r1_wx    <= w_wx;
            r1_wy    <= w_wy;
            r1_eyes0 <= (w_dx == '0) && (w_dy == '0);
            r1_cent0 <= (w_ux == '0) && (w_uy == '0);
        end
    end

    // Stage 2: products; fold eye vector into the right half plane
    always_comb begin
        w_px = {{(CX_W-DIFF_W-CPRE_SH){r1_dx[DIFF_W-1]}}, r1_dx, {CPRE_SH{1'b0}}};
        w_py = {{(CX_W-DIFF_W-CPRE_SH){r1_dy[DIFF_W-1]}}, r1_dy, {CPRE_SH{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_uxx  <= r1_ux * r1_ux;
            r2_uyy  <= r1_uy * r1_uy;
            r2_dxx  <= r1_dx * r1_dx;
            r2_dyy  <= r1_dy * r1_dy;
            r2_uywx <= r1_uy * r1_wx;
            r2_uxwy <= r1_ux * r1_wy;
            r2_uxwx <= r1_ux * r1_wx;
            r2_uywy <= r1_uy * r1_wy;
            if (r1_dx[DIFF_W-1]) begin
                r2_cx <= -w_px;
                r2_cy <= -w_py;
                r2_cz <= r1_dy[DIFF_W-1] ? -ANGLE_PI : ANGLE_PI;
            end else begin
                r2_cx <= w_px;
                r2_cy <= w_py;
                r2_cz <= '0;
            end
        end
    end

    // Stage 3: squared lengths, cross and dot terms
    always_comb begin
        w_nn  = NN_W'(r2_uxx + r2_uyy);
        w_dot = NUM_W'(r2_uxwx) + NUM_W'(r2_uywy);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_nn  <= w_nn;
            r3_dd  <= DD_W'(r2_dxx + r2_dyy);
            r3_cr  <= r2_uywx - r2_uxwy;
            r3_num <= (w_dot <<< 1) - $signed({{(NUM_W-NN_W){1'b0}}, w_nn});
        end
    end

    // Stage 4: magnitudes and signs
    always_comb begin
        w_crn  = -r3_cr;
        w_numn = -r3_num;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_cr_abs <= r3_cr[CR_W-1] ? w_crn[CR_W-2:0] : r3_cr[CR_W-2:0];
            r4_cr_neg <= r3_cr[CR_W-1];
            r4_pnum   <= r3_num[NUM_W-1] ? w_numn[PNUM_W-1:0] : r3_num[PNUM_W-1:0];
            r4_nn     <= r3_nn;
            r4_dd     <= r3_dd;
        end
    end

    // Stage 5: pitch numerator top part against 2|u|^2, flag overflow
    always_comb begin
        w_pr0 = DEN_W'(r4_pnum[PNUM_W-1:PSH]);
        w_pd  = DEN_W'({r4_nn, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_povf  <= (w_pr0 >= w_pd);
            r5_prem  <= (w_pr0 >= w_pd) ? '0 : w_pr0;
            r5_pden  <= w_pd;
            r5_pfeed <= {r4_pnum[PSH-1:0], {RATIO_FRAC_BITS{1'b0}}};
        end
    end

    // CORDIC row
    assign w_cx[0] = r2_cx;
    assign w_cy[0] = r2_cy;
    assign w_cz[0] = r2_cz;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        fpfl_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_shift (CSH_W'(g)),
            .i_x     (w_cx[g]),
            .i_y     (w_cy[g]),
            .i_z     (w_cz[g]),
            .o_x     (w_cx[g+1]),
            .o_y     (w_cy[g+1]),
            .o_z     (w_cz[g+1])
        );
    end

    // Square-root rows for |u| and |d|
    assign w_nrad[0] = {{(RAD_W-NN_W-SQ_SH){1'b0}}, r4_nn, {SQ_SH{1'b0}}};
    assign w_nrem[0] = '0;
    assign w_nrt[0]  = '0;
    assign w_drad[0] = {{(RAD_W-DD_W-SQ_SH){1'b0}}, r4_dd, {SQ_SH{1'b0}}};
    assign w_drem[0] = '0;
    assign w_drt[0]  = '0;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        fpfl_sqrt_cell u_ncell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (w_nrad[g]),
            .i_rem  (w_nrem[g]),
            .i_root (w_nrt[g]),
            .o_rad  (w_nrad[g+1]),
            .o_rem  (w_nrem[g+1]),
            .o_root (w_nrt[g+1])
        );
        fpfl_sqrt_cell u_dcell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (w_drad[g]),
            .i_rem  (w_drem[g]),
            .i_root (w_drt[g]),
            .o_rad  (w_drad[g+1]),
            .o_rem  (w_drem[g+1]),
            .o_root (w_drt[g+1])
        );
    end

    // Pitch divider row
    assign w_prem[0] = r5_prem;
    assign w_pden[0] = r5_pden;
    assign w_pfd[0]  = r5_pfeed;
    assign w_pq[0]   = '0;
    assign w_pov[0]  = r5_povf;

    // Yaw divider row
    assign w_yrem[0] = r32_yrem;
    assign w_yden[0] = r32_yden;
    assign w_yfd[0]  = '0;
    assign w_yq[0]   = '0;
    assign w_yov[0]  = r32_yovf;

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        fpfl_div_cell u_pcell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_prem[g]),
            .i_den  (w_pden[g]),
            .i_feed (w_pfd[g]),
            .i_quo  (w_pq[g]),
            .i_ovf  (w_pov[g]),
            .o_rem  (w_prem[g+1]),
            .o_den  (w_pden[g+1]),
            .o_feed (w_pfd[g+1]),
            .o_quo  (w_pq[g+1]),
            .o_ovf  (w_pov[g+1])
        );
        fpfl_div_cell u_ycell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_yrem[g]),
            .i_den  (w_yden[g]),
            .i_feed (w_yfd[g]),
            .i_quo  (w_yq[g]),
            .i_ovf  (w_yov[g]),
            .o_rem  (w_yrem[g+1]),
            .o_den  (w_yden[g+1]),
            .o_feed (w_yfd[g+1]),
            .o_quo  (w_yq[g+1]),
            .o_ovf  (w_yov[g+1])
        );
    end

    // Roll: round the angle to Q1.15 and saturate
    always_comb begin
        w_zt = $signed({w_cz[CORDIC_STAGES][CZ_W-1], w_cz[CORDIC_STAGES]}) + ROUND_HALF;
        w_zs = w_zt >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_zs > S16_MAX) begin
                r19_roll <= 16'sh7FFF;
            end else if (w_zs < S16_MIN) begin
                r19_roll <= 16'sh8000;
            end else begin
                r19_roll <= w_zs[OUT_W-1:0];
            end
            r23_pitch <= (w_pov[QUO_W] || w_pq[QUO_W][QUO_W-1]) ?
                         '1 : w_pq[QUO_W][OUT_W-1:0];
            r31_den   <= DEN_W'(w_nrt[ROOT_W] * w_drt[ROOT_W]);
        end
    end

    // Yaw setup: numerator top part against |u||d|, flag overflow
    assign w_yr0 = DEN_W'({r_cdly[C_DLY-1], {YAW_SH{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r32_yovf <= (w_yr0 >= r31_den);
            r32_yrem <= (w_yr0 >= r31_den) ? '0 : w_yr0;
            r32_yden <= r31_den;
        end
    end

    // Delay lines to line side results up with the yaw row
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fdly[0] <= {r1_eyes0, r1_cent0};
            for (int i = 1; i < F_DLY; i++) r_fdly[i] <= r_fdly[i-1];
            r_ndly[0] <= r4_cr_neg;
            for (int i = 1; i < N_DLY; i++) r_ndly[i] <= r_ndly[i-1];
            r_cdly[0] <= r4_cr_abs;
            for (int i = 1; i < C_DLY; i++) r_cdly[i] <= r_cdly[i-1];
            r_rdly[0] <= r19_roll;
            for (int i = 1; i < R_DLY; i++) r_rdly[i] <= r_rdly[i-1];
            r_pdly[0] <= r23_pitch;
            for (int i = 1; i < P_DLY; i++) r_pdly[i] <= r_pdly[i-1];
        end
    end

    // Output: cap yaw, apply sign, zero degenerate cases
    always_comb begin
        w_eyes0 = r_fdly[F_DLY-1][1];
        w_cent0 = r_fdly[F_DLY-1][0];
        w_yneg  = r_ndly[N_DLY-1];
        w_ycap  = w_yneg ? QUO_W'(32768) : QUO_W'(32767);
        w_ymag  = (w_yov[QUO_W] || (w_yq[QUO_W] > w_ycap)) ? w_ycap : w_yq[QUO_W];
        n_out.roll   = w_eyes0 ? '0 : r_rdly[R_DLY-1];
        n_out.yaw    = w_yneg ? -$signed(w_ymag[OUT_W-1:0]) : $signed(w_ymag[OUT_W-1:0]);
        n_out.pitch  = r_pdly[P_DLY-1];
        n_out.status = w_eyes0 || w_cent0;
        if (w_eyes0 || w_cent0) begin
            n_out.yaw   = '0;
            n_out.pitch = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_vld[PIPE_LAT];
    assign o_out.data  = r_out;

    `FPFL_ASSERT_IMP(a_ready_tracks_stall, i_clk, i_rst_n, 1'b1,
        i_in.ready == (!o_out.valid || o_out.ready), "input ready disagrees with output stall")
    `FPFL_ASSERT_IMP(a_degenerate_zero, i_clk, i_rst_n, o_out.valid && o_out.data.status,
        (o_out.data.yaw == '0) && (o_out.data.pitch == '0), "degenerate beat has nonzero yaw or pitch")
    `FPFL_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_in.valid && i_in.ready,
        r_vld[1], "accepted beat missing from first stage")

endmodule

### rtl/fpfl_cordic_cell.sv
`timescale 1ns / 1ps

module fpfl_cordic_cell import fpfl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [CSH_W-1:0]       i_shift,
    input  logic signed [CX_W-1:0] i_x,
    input  logic signed [CX_W-1:0] i_y,
    input  logic signed [CZ_W-1:0] i_z,
    output logic signed [CX_W-1:0] o_x,
    output logic signed [CX_W-1:0] o_y,
    output logic signed [CZ_W-1:0] o_z
);

    logic signed [CX_W-1:0] n_x, n_y;
    logic signed [CZ_W-1:0] n_z, w_ang;
    logic signed [CX_W-1:0] r_x, r_y;
    logic signed [CZ_W-1:0] r_z;

    // Rotate toward the x axis by one table angle
    always_comb begin
        w_ang = $signed({{(CZ_W-ATAN_W){1'b0}}, ATAN_TAB[i_shift]});
        if (i_y[CX_W-1]) begin
            n_x = i_x - (i_y >>> i_shift);
            n_y = i_y + (i_x >>> i_shift);
            n_z = i_z - w_ang;
        end else begin
            n_x = i_x + (i_y >>> i_shift);
            n_y = i_y - (i_x >>> i_shift);
            n_z = i_z + w_ang;
        end
    end

    // Advance on enable
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

### rtl/fpfl_sqrt_cell.sv
`timescale 1ns / 1ps

module fpfl_sqrt_cell import fpfl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [SREM_W-1:0] i_rem,
    input  logic [ROOT_W-1:0] i_root,
    output logic [RAD_W-1:0]  o_rad,
    output logic [SREM_W-1:0] o_rem,
    output logic [ROOT_W-1:0] o_root
);

    logic [SREM_W+1:0] w_rem2, w_trial, w_diff;
    logic [RAD_W-1:0]  n_rad, r_rad;
    logic [SREM_W-1:0] n_rem, r_rem;
    logic [ROOT_W-1:0] n_root, r_root;

    // One root bit: bring down two radicand bits and try 4*root+1
    always_comb begin
        w_rem2  = {i_rem, i_rad[RAD_W-1 -: 2]};
        w_trial = {{(SREM_W-ROOT_W){1'b0}}, i_root, 2'b01};
        w_diff  = w_rem2 - w_trial;
        n_rad   = {i_rad[RAD_W-3:0], 2'b00};
        if (w_rem2 >= w_trial) begin
            n_rem  = w_diff[SREM_W-1:0];
            n_root = {i_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = w_rem2[SREM_W-1:0];
            n_root = {i_root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

### rtl/fpfl_div_cell.sv
`timescale 1ns / 1ps

module fpfl_div_cell import fpfl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [DEN_W-1:0] i_den,
    input  logic [QUO_W-1:0] i_feed,
    input  logic [QUO_W-1:0] i_quo,
    input  logic             i_ovf,
    output logic [DEN_W-1:0] o_rem,
    output logic [DEN_W-1:0] o_den,
    output logic [QUO_W-1:0] o_feed,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_ovf
);

    logic [DEN_W:0]   w_r2, w_diff;
    logic             w_ge;
    logic [DEN_W-1:0] n_rem, r_rem, r_den;
    logic [QUO_W-1:0] r_feed, r_quo;
    logic             r_ovf;

    // One quotient bit: shift in the next numerator bit, subtract if it fits
    always_comb begin
        w_r2   = {i_rem, i_feed[QUO_W-1]};
        w_diff = w_r2 - {1'b0, i_den};
        w_ge   = (w_r2 >= {1'b0, i_den});
        n_rem  = w_ge ? w_diff[DEN_W-1:0] : w_r2[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_feed <= {i_feed[QUO_W-2:0], 1'b0};
            r_quo  <= {i_quo[QUO_W-2:0], w_ge};
            r_ovf  <= i_ovf;
        end
    end

    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_feed = r_feed;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;

endmodule
